// File: rtl/trie_insert_search_defines.svh
// Assertion macros used by the trie walker RTL (tis_back).
// Each macro expects the clock clk and the active-low reset arst_n in scope.
`ifndef TRIE_INSERT_SEARCH_DEFINES_SVH
`define TRIE_INSERT_SEARCH_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TIS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TIS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tis_pkg
// Shared types, sizes and codes of the trie insert/search block.
// ----------------------------------------------------------------------------
package tis_pkg;

	// trie geometry
	localparam int ALPHABET = 26;
	localparam int NODES    = 1024;

	localparam int BYTE_W  = 8;
	localparam int WORD_W  = 16;
	localparam int TOTAL_W = 11;
	localparam int SYM_W   = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
	localparam int NODE_W  = $clog2(NODES);
	localparam int CNT_W   = $clog2(NODES + 1);
	localparam int SLOT_W  = $clog2(ALPHABET * NODES);
	localparam int SLOTS   = ALPHABET * NODES;

	localparam logic [BYTE_W:0] ALPHA_LIM = (BYTE_W + 1)'(ALPHABET);

	// command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// reset value of the symbol base register
	localparam logic [BYTE_W-1:0] CHAR_BASE_RST = 8'd97;

	// operation kinds
	localparam logic [1:0] KIND_INSERT     = 2'd0;
	localparam logic [1:0] KIND_EXACT      = 2'd1;
	localparam logic [1:0] KIND_PREFIX     = 2'd2;
	localparam logic [1:0] KIND_PREFIX_ALT = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
	localparam logic [1:0] ST_FULL       = 2'd2;
	localparam logic [1:0] ST_BAD_SYMBOL = 2'd3;

	typedef struct packed {
		logic [1:0]        kind;
		logic [BYTE_W-1:0] char_byte;
		logic              has_char;
		logic              first;
		logic              last;
	} item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [WORD_W-1:0]  word_id;
		logic [TOTAL_W-1:0] node_total;
		logic [WORD_W-1:0]  word_total;
	} result_t;

	// classified character as queued for the back end
	typedef struct packed {
		logic [1:0]       kind;
		logic [SYM_W-1:0] sym;
		logic             bad;
		logic             has_char;
		logic             first;
		logic             last;
	} qent_t;

	// back end status seen by the front end
	typedef struct packed {
		logic clearing;
	} back_stat_t;

	typedef enum logic [1:0] {
		BS_CLEAR,
		BS_IDLE,
		BS_LOOK,
		BS_FLAG
	} back_state_t;

endpackage

// File: rtl/tis_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tis_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/tis_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tis_front
// Command front end: takes items, maps bytes to symbols, queues them.
// ----------------------------------------------------------------------------
module tis_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  tis_pkg::item_t     item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data,
	input  tis_pkg::back_stat_t bstat,
	output logic               q_valid,
	output tis_pkg::qent_t     q_ent,
	input  logic               q_pop
);
	import tis_pkg::*;

	logic [BYTE_W-1:0] char_base_q;
	logic [BYTE_W-1:0] diff;
	qent_t             ent_c;
	qent_t             ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;

	// symbol base register, always ready for a transfer
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_base_q <= CHAR_BASE_RST;
		end else if (cfg_valid && cfg_ready) begin
			char_base_q <= cfg_data;
		end
	end

	// classify the incoming character
	always_comb begin
		diff           = item.char_byte - char_base_q;
		ent_c.kind     = (item.kind == KIND_PREFIX_ALT) ? KIND_PREFIX : item.kind;
		ent_c.sym      = diff[SYM_W-1:0];
		ent_c.bad      = {1'b0, diff} >= ALPHA_LIM;
		ent_c.has_char = item.has_char;
		ent_c.first    = item.first;
		ent_c.last     = item.last;
	end

	// hold off new items while the table clears or the queue is full
	assign busy    = bstat.clearing || (cnt_q == QCNT_W'(QDEPTH));
	assign push    = start && !busy;
	assign q_valid = (cnt_q != '0);
	assign q_ent   = ent_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= ent_c;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (q_pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/tis_back.sv
`timescale 1ns / 1ps
`include "trie_insert_search_defines.svh"
// ----------------------------------------------------------------------------
// tis_back
// Trie walker: clears the tables after reset, then follows or creates child
// links one character at a time and reports the result of each word.
// ----------------------------------------------------------------------------
module tis_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  tis_pkg::qent_t      q_ent,
	output logic                q_pop,
	output tis_pkg::back_stat_t bstat,
	output logic                done,
	output tis_pkg::result_t    result
);
	import tis_pkg::*;

	back_state_t       state_q, state_n;
	logic [NODE_W-1:0] cur_q, cur_n;
	logic [1:0]        fail_q, fail_n;
	logic [CNT_W-1:0]  nodes_q, nodes_n;
	logic [WORD_W-1:0] words_q, words_n;
	logic [SLOT_W-1:0] clr_q;
	logic [SLOT_W-1:0] slot_q, slot_n;
	qent_t             it_q, it_n, fit;
	logic              fin;
	logic              done_q, done_n;
	result_t           res_q, res_n;

	// child table port signals
	logic              c_we;
	logic [SLOT_W-1:0] c_waddr;
	logic [NODE_W-1:0] c_wdata;
	logic [SLOT_W-1:0] c_raddr;
	logic [NODE_W-1:0] c_rdata;

	// accepting flag port signals
	logic              f_we;
	logic [NODE_W-1:0] f_waddr;
	logic              f_wdata;
	logic [NODE_W-1:0] f_raddr;
	logic              f_rdata;

	tis_ram #(.WIDTH(NODE_W), .DEPTH(SLOTS)) u_child (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	tis_ram #(.WIDTH(1), .DEPTH(NODES)) u_flag (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	assign bstat.clearing = (state_q == BS_CLEAR);
	assign done           = done_q;
	assign result         = res_q;

	// next state, table accesses and result
	always_comb begin
		state_n = state_q;
		cur_n   = cur_q;
		fail_n  = fail_q;
		nodes_n = nodes_q;
		words_n = words_q;
		slot_n  = slot_q;
		it_n    = it_q;
		q_pop   = 1'b0;
		fin     = 1'b0;
		done_n  = 1'b0;
		res_n   = res_q;
		c_we    = 1'b0;
		c_waddr = slot_q;
		c_wdata = '0;
		c_raddr = slot_q;
		f_we    = 1'b0;
		f_waddr = cur_q;
		f_wdata = 1'b0;
		f_raddr = cur_q;
		fit     = (state_q == BS_IDLE) ? q_ent : it_q;

		case (state_q)
			// sweep both tables to zero
			BS_CLEAR: begin
				c_we    = 1'b1;
				c_waddr = clr_q;
				f_we    = (clr_q < SLOT_W'(NODES));
				f_waddr = clr_q[NODE_W-1:0];
				if (clr_q == SLOT_W'(SLOTS - 1)) begin
					state_n = BS_IDLE;
				end
			end
			// take the next character, start its child lookup
			BS_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					it_n  = q_ent;
					if (q_ent.first) begin
						cur_n  = '0;
						fail_n = ST_OK;
					end
					if (q_ent.has_char && fail_n == ST_OK) begin
						if (q_ent.bad) begin
							fail_n = ST_BAD_SYMBOL;
							fin    = 1'b1;
						end else begin
							slot_n  = SLOT_W'(SLOT_W'(cur_n) * SLOT_W'(ALPHABET))
								+ SLOT_W'(q_ent.sym);
							c_raddr = slot_n;
							state_n = BS_LOOK;
						end
					end else begin
						fin = 1'b1;
					end
				end
			end
			// follow the link, or create a node on insert
			BS_LOOK: begin
				fin     = 1'b1;
				state_n = BS_IDLE;
				if (c_rdata != '0) begin
					cur_n = c_rdata;
				end else if (it_q.kind != KIND_INSERT) begin
					fail_n = ST_NOT_FOUND;
				end else if (nodes_q >= CNT_W'(NODES)) begin
					fail_n = ST_FULL;
				end else begin
					c_we    = 1'b1;
					c_waddr = slot_q;
					c_wdata = nodes_q[NODE_W-1:0];
					cur_n   = nodes_q[NODE_W-1:0];
					nodes_n = nodes_q + 1'b1;
				end
			end
			// exact search: report by the accepting flag
			BS_FLAG: begin
				res_n.status     = f_rdata ? ST_OK : ST_NOT_FOUND;
				res_n.word_id    = '0;
				res_n.node_total = TOTAL_W'(nodes_q);
				res_n.word_total = words_q;
				done_n           = 1'b1;
				cur_n            = '0;
				fail_n           = ST_OK;
				state_n          = BS_IDLE;
			end
			default: begin
				state_n = BS_IDLE;
			end
		endcase

		// finish a word on its last character
		if (fin && fit.last) begin
			if (fail_n == ST_OK && fit.kind == KIND_EXACT) begin
				f_raddr = cur_n;
				state_n = BS_FLAG;
			end else begin
				res_n.status  = fail_n;
				res_n.word_id = '0;
				if (fail_n == ST_OK && fit.kind == KIND_INSERT) begin
					f_we          = 1'b1;
					f_waddr       = cur_n;
					f_wdata       = 1'b1;
					res_n.word_id = words_q;
					if (words_q != '1) begin
						words_n = words_q + 1'b1;
					end
				end
				res_n.node_total = TOTAL_W'(nodes_n);
				res_n.word_total = words_n;
				done_n           = 1'b1;
				cur_n            = '0;
				fail_n           = ST_OK;
				state_n          = BS_IDLE;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_CLEAR;
			cur_q   <= '0;
			fail_q  <= ST_OK;
			nodes_q <= CNT_W'(1);
			words_q <= '0;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			cur_q   <= cur_n;
			fail_q  <= fail_n;
			nodes_q <= nodes_n;
			words_q <= words_n;
			done_q  <= done_n;
			if (state_q == BS_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		it_q   <= it_n;
		slot_q <= slot_n;
		res_q  <= res_n;
	end

	`TIS_ASSERT_SAME(a_quiet_clear, state_q == BS_CLEAR, !done_q,
		"result strobe during table clear")
	`TIS_ASSERT_NEXT(a_node_grows, state_q == BS_LOOK && c_we,
		nodes_q == $past(nodes_q) + 1'b1, "node count not advanced on node creation")
	`TIS_ASSERT_SAME(a_id_on_insert, done_q && res_q.status != ST_OK,
		res_q.word_id == '0, "word number reported for a failed word")
	`TIS_ASSERT_SAME(a_node_bound, state_q != BS_CLEAR,
		nodes_q <= CNT_W'(NODES) && nodes_q != '0, "node count out of range")

endmodule

// File: rtl/trie_insert_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trie_insert_search
// Prefix tree over a fixed alphabet: insert, exact search, prefix search.
// ----------------------------------------------------------------------------
// Usage:
//   Items: drive item and raise start; the item transfers on a clock edge
//   with start high and busy low. One item carries at most one character of a word
//   with first/last marks and the operation kind.
//   Results: on the last item of a word, done pulses for one cycle with the
//   word's status, number and the node and word totals on result. There is
//   no back-pressure on the result side; the receiver must take it then.
//   Configuration: the symbol base transfers on cfg_valid (cfg_ready is
//   always high); write it only while no word is in flight.
//   Walker: an item without a character is finished from the idle state, an
//   item with a character goes through the child table read, then follow or
//   create, and an exact search adds the accepting-flag read at the end.
//   A two-entry command queue lets start run ahead of the walker.
//   Reset: the child and flag tables are swept to zero, one entry per cycle,
//   over all ALPHABET*NODES (26624) child slots; busy stays high meanwhile.
// ----------------------------------------------------------------------------
module trie_insert_search (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  tis_pkg::item_t   item,
	output logic             done,
	output tis_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_data
);
	import tis_pkg::*;

	back_stat_t bstat;
	logic       q_valid;
	qent_t      q_ent;
	logic       q_pop;

	// accept and classify
	tis_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.bstat     (bstat),
		.q_valid   (q_valid),
		.q_ent     (q_ent),
		.q_pop     (q_pop)
	);

	// walk the trie
	tis_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ent   (q_ent),
		.q_pop   (q_pop),
		.bstat   (bstat),
		.done    (done),
		.result  (result)
	);

endmodule
